### rtl/sbnq_pkg.sv
// ----------------------------------------------------------------------------
// sbnq_pkg
// Types and constants for the sorted box neighbor query block.
// ----------------------------------------------------------------------------
package sbnq_pkg;

   localparam int MAX_HITS   = 64;
   localparam int HIT_CNT_W  = 7;
   localparam int ID_W       = 6;
   localparam int COORD_W    = 32;
   localparam int BOX_W      = 34;
   localparam int RADIUS_W   = 31;
   localparam int SLOT_W     = 6;
   localparam int CNT_DATA_W = 7;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [ID_W-1:0]           id;
   } entry_type;

   typedef struct packed {
      logic in_box;
      logic beyond;
   } box_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WAIT,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_END,
      ST_SW_RD,
      ST_SW_CHK,
      ST_FIN
   } state_type;

endpackage

### rtl/sbnq_if.sv
// ----------------------------------------------------------------------------
// sbnq channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sbnq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [sbnq_pkg::SLOT_W-1:0]           slot;
   logic [sbnq_pkg::ID_W-1:0]             node_id;
   logic signed [sbnq_pkg::COORD_W-1:0]   pos_x;
   logic signed [sbnq_pkg::COORD_W-1:0]   pos_y;
   logic [sbnq_pkg::RADIUS_W-1:0]         radius;
   modport source (output valid, action, slot, node_id, pos_x, pos_y, radius, input ready);
   modport sink   (input valid, action, slot, node_id, pos_x, pos_y, radius, output ready);
endinterface

interface sbnq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbnq_pkg::ID_W-1:0]   hit_id;
   logic                        hit_valid;
   logic                        no_nodes;
   logic                        last;
   modport source (output valid, hit_id, hit_valid, no_nodes, last, input ready);
   modport sink   (input valid, hit_id, hit_valid, no_nodes, last, output ready);
endinterface

interface sbnq_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sbnq_pkg::CNT_DATA_W-1:0]   node_count;
   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

### rtl/sbnq_table.sv
// ----------------------------------------------------------------------------
// sbnq_table
// Node table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbnq_table #(
   parameter int NODES = 64,
   localparam int IW   = (NODES > 1) ? $clog2(NODES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  sbnq_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_addr,
   output sbnq_pkg::entry_type rd_data
);

   sbnq_pkg::entry_type mem [NODES];
   sbnq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sbnq_box.sv
// ----------------------------------------------------------------------------
// sbnq_box
// Holds the query box bounds and tests one table entry against them.
// ----------------------------------------------------------------------------
module sbnq_box (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic signed [sbnq_pkg::COORD_W-1:0]   pos_x,
   input  logic signed [sbnq_pkg::COORD_W-1:0]   pos_y,
   input  logic [sbnq_pkg::RADIUS_W-1:0]         radius,
   input  sbnq_pkg::entry_type                   ent,
   output sbnq_pkg::box_status_type              status
);

   localparam int BW = sbnq_pkg::BOX_W;
   localparam int CW = sbnq_pkg::COORD_W;
   localparam int RW = sbnq_pkg::RADIUS_W;

   logic signed [BW-1:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic signed [BW-1:0] xmin_in, xmax_in, ymin_in, ymax_in;
   logic signed [BW-1:0] px, py, rr, ex, ey;

   always_comb begin
      px = {{(BW-CW){pos_x[CW-1]}}, pos_x};
      py = {{(BW-CW){pos_y[CW-1]}}, pos_y};
      rr = {{(BW-RW){1'b0}}, radius};
      xmin_in = px - rr;
      xmax_in = px + rr;
      ymin_in = py - rr;
      ymax_in = py + rr;
      ex = {{(BW-CW){ent.x[CW-1]}}, ent.x};
      ey = {{(BW-CW){ent.y[CW-1]}}, ent.y};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         xmin_ff <= xmin_in;
         xmax_ff <= xmax_in;
         ymin_ff <= ymin_in;
         ymax_ff <= ymax_in;
      end
   end

   assign status.in_box = (ex >= xmin_ff) && (ex <= xmax_ff) &&
                          (ey >= ymin_ff) && (ey <= ymax_ff);
   assign status.beyond = (ex > xmax_ff);

endmodule

### rtl/sorted_box_neighbor_query_top.sv
// ----------------------------------------------------------------------------
// sorted_box_neighbor_query_top
// Node table kept in x order; square-box queries sweep it and return ids.
//
//  channel  dir  role
//  req_ch   in   slot write (action 0) or box query (action 1)
//  rsp_ch   out  one response per hit, last-marked; one empty response if none
//  csr_ch   in   node_count write
//
//  A query sweeps the table in x order. After writes or a node_count change
//  the first query with more than one node re-sorts in memory first, by
//  bubble passes through the table's one read port and one write port. Reset
//  is synchronous; the table is not cleared. A stalled response holds the
//  sweep.
// ----------------------------------------------------------------------------
module sorted_box_neighbor_query_top #(
   parameter int NODES = 64
) (
   input logic       clock,
   input logic       reset,
   sbnq_req_if.sink  req_ch,
   sbnq_rsp_if.source rsp_ch,
   sbnq_csr_if.sink  csr_ch
);

   localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW = $clog2(NODES + 1);
   localparam int KW = sbnq_pkg::HIT_CNT_W;

   sbnq_pkg::state_type state_ff, state_in;

   logic [IW-1:0]           j_ff, j_in;
   logic [IW-1:0]           lim_ff, lim_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    sorted_ff, sorted_in;
   logic [KW-1:0]           k_ff, k_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [sbnq_pkg::ID_W-1:0] pend_id_ff, pend_id_in;
   logic                    empty_ff, empty_in;
   sbnq_pkg::entry_type     carry_ff, carry_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [sbnq_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                      rsp_hv_ff, rsp_hv_in;
   logic                      rsp_nn_ff, rsp_nn_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                    wr_en, rd_en;
   logic [IW-1:0]           wr_addr, rd_addr;
   sbnq_pkg::entry_type     wr_data, rd_data;
   sbnq_pkg::box_status_type box_st;

   logic req_acc, is_query, is_write, slot_ok, out_free;
   logic hit, stall_chk, sweep_end, swap, pass_end;

   sbnq_table #(.NODES(NODES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sbnq_box u_box (
      .clock  (clock),
      .load   (req_acc && is_query),
      .pos_x  (req_ch.pos_x),
      .pos_y  (req_ch.pos_y),
      .radius (req_ch.radius),
      .ent    (rd_data),
      .status (box_st)
   );

   assign req_ch.ready = (state_ff == sbnq_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc  = req_ch.valid && req_ch.ready;
   assign is_query = (req_ch.action == sbnq_pkg::ACT_QUERY);
   assign is_write = (req_ch.action == sbnq_pkg::ACT_WRITE);
   assign slot_ok  = (32'(req_ch.slot) < NODES);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign hit       = box_st.in_box;
   assign stall_chk = hit && pend_valid_ff && !out_free;
   assign sweep_end = (hit && (32'(k_ff) == sbnq_pkg::MAX_HITS - 1)) || box_st.beyond ||
                      ((CW'(j_ff) + CW'(1)) == count_ff);
   assign swap      = $signed(rd_data.x) < $signed(carry_ff.x);
   assign pass_end  = ((j_ff + IW'(1)) == lim_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbnq_pkg::ST_IDLE: begin
            if (req_acc && is_query) begin
               if (count_ff == '0) begin
                  state_in = sbnq_pkg::ST_FIN;
               end else if (!sorted_ff && (count_ff > CW'(1))) begin
                  state_in = sbnq_pkg::ST_LD_RD;
               end else begin
                  state_in = sbnq_pkg::ST_SW_RD;
               end
            end
         end
         sbnq_pkg::ST_LD_RD:    state_in = sbnq_pkg::ST_LD_WAIT;
         sbnq_pkg::ST_LD_WAIT:  state_in = sbnq_pkg::ST_SORT_RD;
         sbnq_pkg::ST_SORT_RD:  state_in = sbnq_pkg::ST_SORT_CMP;
         sbnq_pkg::ST_SORT_CMP: begin
            state_in = pass_end ? sbnq_pkg::ST_SORT_END : sbnq_pkg::ST_SORT_RD;
         end
         sbnq_pkg::ST_SORT_END: begin
            state_in = (lim_ff == IW'(1)) ? sbnq_pkg::ST_SW_RD : sbnq_pkg::ST_LD_RD;
         end
         sbnq_pkg::ST_SW_RD:    state_in = sbnq_pkg::ST_SW_CHK;
         sbnq_pkg::ST_SW_CHK: begin
            if (!stall_chk) begin
               state_in = sweep_end ? sbnq_pkg::ST_FIN : sbnq_pkg::ST_SW_RD;
            end
         end
         sbnq_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = sbnq_pkg::ST_IDLE;
            end
         end
         default: state_in = sbnq_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      j_in          = j_ff;
      lim_in        = lim_ff;
      count_in      = count_ff;
      sorted_in     = sorted_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      empty_in      = empty_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_nn_in     = rsp_nn_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = j_ff;
      wr_data       = carry_ff;
      rd_en         = 1'b0;
      rd_addr       = j_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         count_in  = (32'(csr_ch.node_count) > NODES) ? CW'(NODES)
                                                      : CW'(csr_ch.node_count);
         sorted_in = 1'b0;
      end

      case (state_ff)
         sbnq_pkg::ST_IDLE: begin
            if (req_acc && is_write && slot_ok) begin
               wr_en      = 1'b1;
               wr_addr    = IW'(req_ch.slot);
               wr_data.x  = req_ch.pos_x;
               wr_data.y  = req_ch.pos_y;
               wr_data.id = req_ch.node_id;
               sorted_in  = 1'b0;
            end
            if (req_acc && is_query) begin
               j_in          = '0;
               lim_in        = IW'(count_ff - CW'(1));
               k_in          = '0;
               pend_valid_in = 1'b0;
               pend_id_in    = '0;
               empty_in      = (count_ff == '0);
            end
         end
         sbnq_pkg::ST_LD_RD: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         sbnq_pkg::ST_LD_WAIT: begin
            carry_in = rd_data;
            j_in     = '0;
         end
         sbnq_pkg::ST_SORT_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_ff + IW'(1);
         end
         sbnq_pkg::ST_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (swap) begin
               wr_data = rd_data;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data;
            end
            j_in = j_ff + IW'(1);
         end
         sbnq_pkg::ST_SORT_END: begin
            wr_en   = 1'b1;
            wr_addr = lim_ff;
            wr_data = carry_ff;
            if (lim_ff == IW'(1)) begin
               sorted_in = 1'b1;
               j_in      = '0;
               lim_in    = IW'(count_ff - CW'(1));
            end else begin
               lim_in = lim_ff - IW'(1);
            end
         end
         sbnq_pkg::ST_SW_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_ff;
         end
         sbnq_pkg::ST_SW_CHK: begin
            if (!stall_chk) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = pend_id_ff;
                     rsp_hv_in    = 1'b1;
                     rsp_nn_in    = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_data.id;
                  k_in          = k_ff + KW'(1);
               end
               j_in = j_ff + IW'(1);
            end
         end
         sbnq_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = pend_valid_ff ? pend_id_ff : '0;
               rsp_hv_in    = pend_valid_ff;
               rsp_nn_in    = empty_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sbnq_pkg::ST_IDLE;
         count_ff      <= '0;
         sorted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         k_ff          <= '0;
         empty_ff      <= 1'b0;
         j_ff          <= '0;
         lim_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sorted_ff     <= sorted_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         k_ff          <= k_in;
         empty_ff      <= empty_in;
         j_ff          <= j_in;
         lim_ff        <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff  <= pend_id_in;
      carry_ff    <= carry_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_hv_ff   <= rsp_hv_in;
      rsp_nn_ff   <= rsp_nn_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.hit_id    = rsp_id_ff;
   assign rsp_ch.hit_valid = rsp_hv_ff;
   assign rsp_ch.no_nodes  = rsp_nn_ff;
   assign rsp_ch.last      = rsp_last_ff;

   a_sorted_after_sort: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbnq_pkg::ST_SORT_END && lim_ff == IW'(1) && !csr_ch.valid)
         |=> sorted_ff)
      else $error("table not marked sorted after final pass");

   a_hit_limit: assert property (@(posedge clock) disable iff (reset)
      32'(k_ff) <= sbnq_pkg::MAX_HITS)
      else $error("hit count over limit");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbnq_pkg::ST_SW_CHK) |-> (CW'(j_ff) < count_ff))
      else $error("sweep index past node count");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hv_ff) |-> rsp_last_ff)
      else $error("empty response not last");

endmodule
